### src/brbuf_pkg.sv
// shared constants, codes and types of the ring byte buffer
`timescale 1ns / 1ps

package brbuf_pkg;

	localparam int STORE_DEPTH = 1024;
	localparam int MAX_PATTERN = 8;

	localparam int ADDR_W   = $clog2(STORE_DEPTH);
	localparam int CNT_W    = ADDR_W + 1;
	localparam int PLEN_W   = 4;
	localparam int PAT_W    = 64;
	localparam int ACT_W    = 3;
	localparam int CFG_IDX_W = 2;

	// beat widths, padded to whole bytes
	localparam int IN_W        = 8 + CNT_W;
	localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
	localparam int RES_W       = 2 + 2 + ADDR_W + 3 * CNT_W;
	localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

	localparam logic [CNT_W-1:0]  CAP_RESET  = CNT_W'(STORE_DEPTH);
	localparam logic [PLEN_W-1:0] PLEN_RESET = PLEN_W'(2);

	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_PLEN     = CFG_IDX_W'(2);

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_MISS  = 2'd1;
	localparam logic [1:0] ST_SHORT = 2'd2;

	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH,
		ACT_CONSUME,
		ACT_COMMIT,
		ACT_SPAN_ALL,
		ACT_SPAN_N,
		ACT_FREE_SPAN,
		ACT_SEARCH,
		ACT_COMPARE
	} action_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_READ,
		S_SHIFT,
		S_CHECK,
		S_FINISH
	} seq_state_t;

	// input beat payload, data byte in the low bits
	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [7:0]       data_byte;
	} item_t;

	// result payload, status in the low bits
	typedef struct packed {
		logic [CNT_W-1:0]  done_count;
		logic [CNT_W-1:0]  second_length;
		logic [CNT_W-1:0]  first_length;
		logic [ADDR_W-1:0] first_offset;
		logic [1:0]        segment_count;
		logic [1:0]        status;
	} result_t;

	// store access request from the sequencer
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [7:0]        wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

endpackage

### src/brbuf_store.sv
// byte store: one write port, one read port with registered data
`timescale 1ns / 1ps

module brbuf_store (
	input  logic                clk,
	input  brbuf_pkg::mem_req_t req,
	output logic [7:0]          rdata_q
);
	import brbuf_pkg::*;

	logic [7:0] mem_q [STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem_q[req.raddr];
		end
	end

endmodule

### src/brbuf_match.sv
// byte window and pattern comparator used by search and compare
`timescale 1ns / 1ps

module brbuf_match (
	input  logic                          clk,
	input  logic                          shift_en,
	input  logic [7:0]                    byte_in,
	input  logic [brbuf_pkg::PAT_W-1:0]   pattern,
	input  logic [brbuf_pkg::PLEN_W-1:0]  plen,
	output logic                          hit
);
	import brbuf_pkg::*;

	localparam int WIN_IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	// win_q[0] is the newest byte
	logic [7:0] win_q [MAX_PATTERN];

	always_ff @(posedge clk) begin
		if (shift_en) begin
			win_q[0] <= byte_in;
			for (int j = 1; j < MAX_PATTERN; j++) begin
				win_q[j] <= win_q[j-1];
			end
		end
	end

	// pattern byte k sits at window position plen-1-k
	always_comb begin
		logic [WIN_IDX_W-1:0] pos;
		hit = 1'b1;
		for (int k = 0; k < MAX_PATTERN; k++) begin
			pos = WIN_IDX_W'(plen - PLEN_W'(k) - PLEN_W'(1));
			if (PLEN_W'(k) < plen) begin
				if (win_q[pos] != pattern[8*k +: 8]) begin
					hit = 1'b0;
				end
			end
		end
	end

endmodule

### src/brbuf_seq.sv
// sequencer: pointers, fill count and the byte-walking scan
`timescale 1ns / 1ps

module brbuf_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  brbuf_pkg::action_t            in_action,
	input  brbuf_pkg::item_t              in_item,
	input  logic                          cap_wr,
	input  logic [brbuf_pkg::CNT_W-1:0]   cap,
	input  logic [brbuf_pkg::PLEN_W-1:0]  plen,
	input  logic                          out_free,
	output logic                          res_valid,
	output brbuf_pkg::result_t            res,
	output brbuf_pkg::mem_req_t           mem_req,
	output logic                          shift_en,
	input  logic                          hit
);
	import brbuf_pkg::*;

	seq_state_t        state_q, state_d;
	action_t           act_q, act_d;
	item_t             item_q, item_d;
	logic [ADDR_W-1:0] rp_q, rp_d;
	logic [ADDR_W-1:0] wp_q, wp_d;
	logic [CNT_W-1:0]  fill_q, fill_d;
	logic [ADDR_W-1:0] addr_q, addr_d;
	logic [CNT_W-1:0]  idx_q, idx_d;
	logic [CNT_W-1:0]  mofs_q, mofs_d;
	logic              found_q, found_d;
	logic [1:0]        st_q, st_d;
	logic [CNT_W-1:0]  plen_x;

	assign plen_x = CNT_W'(plen);

	function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] base,
			input logic [CNT_W-1:0] n, input logic [CNT_W-1:0] c);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(base) + (CNT_W+1)'(n);
		if (s >= (CNT_W+1)'(c)) begin
			s = s - (CNT_W+1)'(c);
		end
		return ADDR_W'(s);
	endfunction

	function automatic result_t make_span(input logic [ADDR_W-1:0] start,
			input logic [CNT_W-1:0] len, input logic [CNT_W-1:0] c);
		result_t        r;
		logic [CNT_W:0] endp;
		logic [CNT_W-1:0] head;
		r = '0;
		endp = (CNT_W+1)'(start) + (CNT_W+1)'(len);
		head = c - CNT_W'(start);
		if (len == '0) begin
			r.status = ST_MISS;
		end else begin
			r.status = ST_OK;
			r.first_offset = start;
			if (endp > (CNT_W+1)'(c)) begin
				r.segment_count = 2'd2;
				r.first_length = head;
				r.second_length = len - head;
			end else begin
				r.segment_count = 2'd1;
				r.first_length = len;
			end
		end
		return r;
	endfunction

	// search and compare result from the scan outcome
	function automatic result_t scan_result(input logic found, input logic [1:0] st,
			input logic [ADDR_W-1:0] rp, input logic [CNT_W-1:0] mofs,
			input logic [CNT_W-1:0] c);
		result_t        r;
		logic [CNT_W:0] sum;
		logic [CNT_W:0] q;
		r = '0;
		sum = (CNT_W+1)'(rp) + (CNT_W+1)'(mofs);
		q = sum - (CNT_W+1)'(c);
		if (!found) begin
			r.status = st;
		end else begin
			r.status = ST_OK;
			r.first_offset = rp;
			if (sum < (CNT_W+1)'(c)) begin
				r.segment_count = 2'd1;
				r.first_length = mofs;
			end else begin
				r.first_length = c - CNT_W'(rp);
				if (q == '0) begin
					r.segment_count = 2'd1;
				end else begin
					r.segment_count = 2'd2;
					r.second_length = CNT_W'(q);
				end
			end
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			act_q   <= ACT_PUSH;
			item_q  <= '0;
			rp_q    <= '0;
			wp_q    <= '0;
			fill_q  <= '0;
			addr_q  <= '0;
			idx_q   <= '0;
			mofs_q  <= '0;
			found_q <= 1'b0;
			st_q    <= ST_OK;
		end else begin
			state_q <= state_d;
			act_q   <= act_d;
			item_q  <= item_d;
			addr_q  <= addr_d;
			idx_q   <= idx_d;
			mofs_q  <= mofs_d;
			found_q <= found_d;
			st_q    <= st_d;
			if (cap_wr) begin
				rp_q   <= '0;
				wp_q   <= '0;
				fill_q <= '0;
			end else begin
				rp_q   <= rp_d;
				wp_q   <= wp_d;
				fill_q <= fill_d;
			end
		end
	end

	always_comb begin
		logic [CNT_W-1:0] n;
		logic [CNT_W-1:0] room;
		logic [CNT_W-1:0] fill_new;
		logic [CNT_W:0]   next_addr;

		state_d = state_q;
		act_d   = act_q;
		item_d  = item_q;
		rp_d    = rp_q;
		wp_d    = wp_q;
		fill_d  = fill_q;
		addr_d  = addr_q;
		idx_d   = idx_q;
		mofs_d  = mofs_q;
		found_d = found_q;
		st_d    = st_q;

		in_ready  = (state_q == S_IDLE);
		res_valid = 1'b0;
		res       = '0;
		mem_req   = '0;
		shift_en  = 1'b0;

		room      = cap - fill_q;
		n         = '0;
		fill_new  = '0;
		next_addr = (CNT_W+1)'(addr_q) + (CNT_W+1)'(1);

		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					act_d   = in_action;
					item_d  = in_item;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				case (act_q)
					ACT_SEARCH, ACT_COMPARE: begin
						if (fill_q < plen_x) begin
							found_d = 1'b0;
							st_d    = (act_q == ACT_SEARCH) ? ST_MISS : ST_SHORT;
							state_d = S_FINISH;
						end else begin
							addr_d  = rp_q;
							idx_d   = '0;
							state_d = S_READ;
						end
					end
					default: begin
						if (out_free) begin
							res_valid = 1'b1;
							state_d   = S_IDLE;
							case (act_q)
								ACT_PUSH: begin
									if (fill_q < cap) begin
										mem_req.we    = 1'b1;
										mem_req.waddr = wp_q;
										mem_req.wdata = item_q.data_byte;
										wp_d          = ring_add(wp_q, CNT_W'(1), cap);
										fill_d        = fill_q + CNT_W'(1);
										res.done_count = CNT_W'(1);
									end
								end
								ACT_CONSUME: begin
									n = (item_q.count < fill_q) ? item_q.count : fill_q;
									fill_new = fill_q - n;
									if (n != '0) begin
										fill_d = fill_new;
										if (fill_new == '0) begin
											rp_d = '0;
											wp_d = '0;
										end else begin
											rp_d = ring_add(rp_q, n, cap);
										end
									end
									res.done_count = n;
								end
								ACT_COMMIT: begin
									n = (item_q.count < room) ? item_q.count : room;
									wp_d   = ring_add(wp_q, n, cap);
									fill_d = fill_q + n;
									res.done_count = n;
								end
								ACT_SPAN_ALL: begin
									res = make_span(rp_q, fill_q, cap);
								end
								ACT_SPAN_N: begin
									res = make_span(rp_q,
										(item_q.count > fill_q) ? '0 : item_q.count, cap);
								end
								ACT_FREE_SPAN: begin
									res = make_span(wp_q, room, cap);
								end
								default: begin
								end
							endcase
						end
					end
				endcase
			end
			S_READ: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = addr_q;
				state_d       = S_SHIFT;
			end
			S_SHIFT: begin
				shift_en = 1'b1;
				idx_d    = idx_q + CNT_W'(1);
				addr_d   = (next_addr == (CNT_W+1)'(cap)) ? '0 : ADDR_W'(next_addr);
				state_d  = S_CHECK;
			end
			S_CHECK: begin
				if (act_q == ACT_COMPARE && idx_q == plen_x) begin
					found_d = 1'b0;
					st_d    = hit ? ST_OK : ST_MISS;
					state_d = S_FINISH;
				end else if (act_q == ACT_SEARCH && idx_q >= plen_x && hit) begin
					found_d = 1'b1;
					mofs_d  = idx_q - plen_x;
					state_d = S_FINISH;
				end else if (act_q == ACT_SEARCH && idx_q == fill_q) begin
					found_d = 1'b0;
					st_d    = ST_MISS;
					state_d = S_FINISH;
				end else begin
					mem_req.re    = 1'b1;
					mem_req.raddr = addr_q;
					state_d       = S_SHIFT;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					res_valid = 1'b1;
					res       = scan_result(found_q, st_q, rp_q, mofs_q, cap);
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= cap)
		else $error("fill count above capacity");

	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(CNT_W'(rp_q) < cap) && (CNT_W'(wp_q) < cap))
		else $error("pointer at or beyond capacity");

	a_ptr_meet: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == '0 || fill_q == cap) |-> rp_q == wp_q)
		else $error("pointers apart while ring is empty or full");

	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> out_free)
		else $error("result issued while output register is busy");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CHECK |-> (idx_q <= fill_q && idx_q != '0))
		else $error("scan walked past the fill");
`endif

endmodule

### src/byte_ring_buffer_with_delimiter_search.sv
// top level of the ring byte buffer with pattern search
`timescale 1ns / 1ps

// Ring byte buffer with pattern search. A store of STORE_DEPTH bytes, of which
// the first `capacity` form a ring with read pointer, write pointer and fill
// count. One input beat carries one action (push, consume, commit, span all,
// span n, free span, search, compare) and gives exactly one result beat.
// Timing: the block takes one beat at a time and is not ready while it works.
// Push, consume, commit and the span actions accept the beat, then execute
// and load the output register once it is free. Search and compare walk the
// filled bytes from the read pointer through the single read port of the
// store, one byte at a time (read, then shift into an eight-byte window
// checked by one comparator); a compare stops after pattern_length bytes,
// a search at its first match or at the end of the fill. A search or compare
// on a ring that holds fewer bytes than the pattern finishes without a scan.
// A waiting result sits in the output register, and the next beat is taken
// while it waits. The store has no reset and no clearing pass: bytes that were
// committed but never pushed read as unknown. The user must write
// configuration only while the block is idle; the block does not enforce it.
// Writing capacity empties the ring.

module byte_ring_buffer_with_delimiter_search (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// fields from bit 0: data_byte[7:0], count[18:8], zero pad
	input  logic [brbuf_pkg::IN_TDATA_W-1:0]      s_tdata,
	// fields from bit 0: action[2:0]
	input  logic [brbuf_pkg::ACT_W-1:0]           s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// fields from bit 0: status[1:0], segment_count[3:2], first_offset[13:4],
	// first_length[24:14], second_length[35:25], done_count[46:36], zero pad
	output logic [brbuf_pkg::OUT_TDATA_W-1:0]     m_tdata,
	input  logic                                  cfg_we,
	input  logic [brbuf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [brbuf_pkg::PAT_W-1:0]           cfg_wdata
);
	import brbuf_pkg::*;

	// configuration, held as effective values
	logic [CNT_W-1:0]  cap_q;
	logic [PAT_W-1:0]  pat_q;
	logic [PLEN_W-1:0] plen_q;
	logic              cap_wr;

	// output register
	logic              out_valid_q;
	result_t           out_q;
	logic              out_free;

	// sequencer links
	logic              res_valid;
	result_t           res;
	mem_req_t          mem_req;
	logic              shift_en;
	logic              hit;
	logic [7:0]        rdata;
	item_t             in_item;
	action_t           in_action;

	function automatic logic [CNT_W-1:0] clamp_cap(input logic [CNT_W-1:0] v);
		logic [CNT_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = CNT_W'(1);
		end else if (v > CNT_W'(STORE_DEPTH)) begin
			r = CNT_W'(STORE_DEPTH);
		end
		return r;
	endfunction

	function automatic logic [PLEN_W-1:0] clamp_plen(input logic [PLEN_W-1:0] v);
		logic [PLEN_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = PLEN_W'(1);
		end else if (v > PLEN_W'(MAX_PATTERN)) begin
			r = PLEN_W'(MAX_PATTERN);
		end
		return r;
	endfunction

	assign cap_wr = cfg_we && (cfg_index == REG_CAPACITY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CAP_RESET;
			pat_q  <= '0;
			plen_q <= PLEN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CAPACITY: cap_q  <= clamp_cap(cfg_wdata[CNT_W-1:0]);
				REG_PATTERN:  pat_q  <= cfg_wdata;
				REG_PLEN:     plen_q <= clamp_plen(cfg_wdata[PLEN_W-1:0]);
				default: begin
				end
			endcase
		end
	end

	// input beat unpacking
	assign in_item   = item_t'(s_tdata[IN_W-1:0]);
	assign in_action = action_t'(s_tuser);

	brbuf_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_action (in_action),
		.in_item   (in_item),
		.cap_wr    (cap_wr),
		.cap       (cap_q),
		.plen      (plen_q),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res       (res),
		.mem_req   (mem_req),
		.shift_en  (shift_en),
		.hit       (hit)
	);

	brbuf_store u_store (
		.clk     (clk),
		.req     (mem_req),
		.rdata_q (rdata)
	);

	brbuf_match u_match (
		.clk      (clk),
		.shift_en (shift_en),
		.byte_in  (rdata),
		.pattern  (pat_q),
		.plen     (plen_q),
		.hit      (hit)
	);

	// result beat holding register; the sequencer loads it only when free
	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TDATA_W'(out_q);

endmodule
